@@ rtl/core/hit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hit_pkg;
  localparam int MAX_PIXELS_DEF = 1048576;
  localparam int MAX_ROUNDS_DEF = 32;
  localparam int NBINS = 256;
  localparam int BIN_W = 8;
  localparam int CNT_W = 25;
  localparam int SUM_W = 33;
  localparam logic [7:0] INIT_GUESS_RST = 8'd10;
  localparam logic [7:0] TOL_RST = 8'd5;
  localparam logic [0:0] REG_INITIAL_GUESS = 1'b0;
  localparam logic [0:0] REG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       converged;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [7:0] guess;
    logic [7:0] tol;
  } solve_req_t;
endpackage
`default_nettype wire

@@ rtl/core/hit_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/hit_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module hit_div #(
  parameter int NW = 33,
  parameter int DW = 25
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire [NW-1:0]  num,
  input  wire [DW-1:0]  den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  always_comb trial = {rem[DW-1:0], n[NW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        n    <= num;
        d    <= den;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial;
          n   <= {n[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], n[NW-1]};
          n   <= {n[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = n;
endmodule
`default_nettype wire

@@ rtl/core/histogram_intermeans_threshold_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Histogram intermeans threshold.
// Pixels: one request per cycle while accepting, until the last pixel; a pixel equal to the
// one before uses the forwarded count. Last pixel: the update finishes, a prefix pass runs,
// then rounds of two serial divides on one shared divider, at most MAX_ROUNDS rounds.
// No pixel is taken from the last pixel until the result is taken and the clear ends.
// Reset (rst, synchronous): histogram clear; initial_guess 10, tolerance 5.
module histogram_intermeans_threshold_core #(
  parameter int MAX_PIXELS = hit_pkg::MAX_PIXELS_DEF,
  parameter int MAX_ROUNDS = hit_pkg::MAX_ROUNDS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire hit_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output hit_pkg::out_item_t     out_data,
  input  wire                    cfg_we,
  input  wire [0:0]              cfg_index,
  input  wire [7:0]              cfg_data
);
  localparam int BW = hit_pkg::BIN_W;
  localparam int CW = hit_pkg::CNT_W;
  localparam int SW = hit_pkg::SUM_W;
  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int RW = $clog2(MAX_ROUNDS + 1);

  localparam logic [3:0] S_CLR = 4'd0, S_ACC = 4'd1, S_PRE = 4'd2, S_TOP = 4'd3,
                         S_CHK = 4'd4, S_RD = 4'd5, S_RDW = 4'd6, S_DLO = 4'd7,
                         S_DHI = 4'd8, S_OUT = 4'd9, S_PREW = 4'd10;

  logic [3:0] state;
  logic [7:0] initial_guess, tolerance;
  logic [BW:0] idx;
  logic [PW-1:0] frame_pixels;
  logic [RW-1:0] round_count;
  logic [7:0] guess_now, guess_before;
  logic last_seen;

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_guess <= hit_pkg::INIT_GUESS_RST;
      tolerance     <= hit_pkg::TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hit_pkg::REG_INITIAL_GUESS: initial_guess <= cfg_data;
        hit_pkg::REG_TOLERANCE:     tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Histogram RAM: read-modify-write in the cycle after the request.
  logic          h_we;
  logic [BW-1:0] h_waddr, h_raddr;
  logic [CW-1:0] h_wdata, h_rdata;
  hit_ram #(.WIDTH(CW), .DEPTH(hit_pkg::NBINS)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));

  // Prefix RAM: cumulative count and cumulative sum side by side at one address.
  logic          c_we;
  logic [BW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] cc_rdata;
  logic [SW-1:0] cs_rdata;
  logic [CW-1:0] run_c;
  logic [SW-1:0] run_s;
  logic [CW+SW-1:0] c_rdata;
  hit_ram #(.WIDTH(CW+SW), .DEPTH(hit_pkg::NBINS)) u_cum (
    .clk, .we(c_we), .waddr(c_waddr), .wdata({run_c, run_s}), .raddr(c_raddr),
    .rdata(c_rdata));
  assign cc_rdata = c_rdata[CW+SW-1:SW];
  assign cs_rdata = c_rdata[SW-1:0];

  // Pending update stage.
  logic          p_vld;
  logic [BW-1:0] p_bin;
  logic [CW-1:0] p_val;
  logic [CW-1:0] cur;
  logic          f_vld;
  logic [BW-1:0] f_bin;

  assign in_ready = (state == S_ACC) && !last_seen;
  wire take = in_valid && in_ready;
  wire count_ok = frame_pixels < PW'(MAX_PIXELS);

  // The RAM read misses a write made on the same edge: forward the count just written.
  always_comb cur = (f_vld && f_bin == p_bin) ? p_val : h_rdata;

  // Divider.
  logic          d_start, d_done;
  logic [SW-1:0] d_num, d_quo;
  logic [CW-1:0] d_den;
  hit_div #(.NW(SW), .DW(CW)) u_div (
    .clk, .rst, .start(d_start), .num(d_num), .den(d_den), .done(d_done), .quo(d_quo));

  logic [CW-1:0] tot_c, g_c;
  logic [SW-1:0] tot_s, g_s, lo_mean;
  logic [BW:0]   pidx;
  logic          pvld;
  logic [CW-1:0] hi_c;
  logic [SW:0]   msum;
  logic [7:0]    diff;
  logic          conv;

  always_comb begin
    diff = (guess_now > guess_before) ? guess_now - guess_before : guess_before - guess_now;
    hi_c = tot_c - g_c;
    msum = {1'b0, lo_mean} + {1'b0, d_quo};
  end

  always_comb begin
    h_we = 1'b0; h_waddr = p_bin; h_wdata = p_val + 1'b1; h_raddr = in_data.pixel;
    c_we = pvld; c_waddr = pidx[BW-1:0]; c_raddr = guess_now;
    case (state)
      S_CLR: begin h_we = 1'b1; h_waddr = idx[BW-1:0]; h_wdata = '0; end
      S_ACC: begin h_we = p_vld; h_wdata = cur + 1'b1; end
      S_PRE, S_PREW: begin
        h_raddr = idx[BW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    d_start <= 1'b0;
    if (rst) begin
      state <= S_CLR; idx <= '0; p_vld <= 1'b0; pvld <= 1'b0; f_vld <= 1'b0;
      frame_pixels <= '0; last_seen <= 1'b0; out_valid <= 1'b0;
      guess_now <= '0; guess_before <= '0; round_count <= '0;
    end else begin
      case (state)
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == (BW+1)'(hit_pkg::NBINS - 1)) begin
            state <= S_ACC; idx <= '0; frame_pixels <= '0; last_seen <= 1'b0;
          end
        end
        S_ACC: begin
          p_vld <= take && count_ok;
          p_bin <= in_data.pixel;
          f_vld <= p_vld;
          f_bin <= p_bin;
          p_val <= cur + 1'b1;
          if (take && count_ok) frame_pixels <= frame_pixels + 1'b1;
          if (take && in_data.last_pixel) last_seen <= 1'b1;
          if (last_seen && !p_vld) begin
            state <= S_PREW; idx <= '0; run_c <= '0; run_s <= '0;
          end
        end
        S_PREW: begin idx <= idx + 1'b1; state <= S_PRE; pvld <= 1'b0; end
        S_PRE: begin
          // h_rdata is bin idx-1.
          run_c <= (pvld ? run_c : '0) + h_rdata;
          run_s <= (pvld ? run_s : '0) + SW'(h_rdata) * SW'(idx - 1'b1);
          pidx <= idx - 1'b1; pvld <= 1'b1;
          idx <= idx + 1'b1;
          if (idx == (BW+1)'(hit_pkg::NBINS)) state <= S_TOP;
        end
        S_TOP: begin
          // Running totals now cover every bin.
          pvld <= 1'b0;
          tot_c <= run_c; tot_s <= run_s;
          guess_now <= initial_guess; guess_before <= '0; round_count <= '0;
          state <= S_RDW;
        end
        S_RDW: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (diff <= tolerance) begin
            conv <= 1'b1; state <= S_OUT; out_valid <= 1'b1;
          end else if (round_count >= RW'(MAX_ROUNDS)) begin
            conv <= 1'b0; state <= S_OUT; out_valid <= 1'b1;
          end else state <= S_RD;
        end
        S_RD: begin
          g_c <= cc_rdata; g_s <= cs_rdata;
          d_num <= cs_rdata; d_den <= (cc_rdata == '0) ? CW'(1) : cc_rdata;
          d_start <= 1'b1; state <= S_DLO;
        end
        S_DLO: if (d_done) begin
          lo_mean <= d_quo;
          d_num <= tot_s - g_s; d_den <= (hi_c == '0) ? CW'(1) : hi_c;
          d_start <= 1'b1; state <= S_DHI;
        end
        S_DHI: if (d_done) begin
          guess_before <= guess_now;
          guess_now <= msum[8:1];
          round_count <= round_count + 1'b1;
          state <= S_CHK;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; state <= S_CLR; idx <= '0;
        end
        default: state <= S_CLR;
      endcase
    end
  end

  assign out_data.threshold = guess_now;
  assign out_data.converged = conv;
endmodule
`default_nettype wire
